// ===== rtl/clfc_pkg.sv =====
`default_nettype none

package clfc_pkg;

    // Widths of the request and result fields and of the internal levels and timers.
    localparam int unsigned SAMPLE_W  = 8;
    localparam int unsigned DUTY_W    = 10;
    localparam int unsigned LEVEL_W   = 8;
    localparam int unsigned TIMER_W   = 16;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOOR_DEBOUNCE   = 3'd0,
        CFG_ENGINE_DEBOUNCE = 3'd1,
        CFG_FADE_DIVIDER    = 3'd2,
        CFG_OFF_DELAY       = 3'd3,
        CFG_AUTO_OFF        = 3'd4,
        CFG_ENGINE_THRESH   = 3'd5,
        CFG_MAX_BRIGHTNESS  = 3'd6
    } t_cfg_idx;

    // Register values after reset.
    localparam logic [LEVEL_W-1:0] RST_DOOR_DEBOUNCE   = 8'd10;
    localparam logic [LEVEL_W-1:0] RST_ENGINE_DEBOUNCE = 8'd10;
    localparam logic [LEVEL_W-1:0] RST_FADE_DIVIDER    = 8'd4;
    localparam logic [TIMER_W-1:0] RST_OFF_DELAY       = 16'd1220;
    localparam logic [TIMER_W-1:0] RST_AUTO_OFF        = 16'd14640;
    localparam logic [LEVEL_W-1:0] RST_ENGINE_THRESH   = 8'd221;
    localparam logic [LEVEL_W-1:0] RST_MAX_BRIGHTNESS  = 8'd101;

endpackage

`default_nettype wire

// ===== rtl/clfc_in_if.sv =====
`default_nettype none

interface clfc_in_if;
    import clfc_pkg::*;

    logic                valid;
    logic                ready;
    logic                door_level;
    logic [SAMPLE_W-1:0] supply_sample;

    modport source (output valid, output door_level, output supply_sample, input ready);
    modport sink   (input valid, input door_level, input supply_sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/clfc_out_if.sv =====
`default_nettype none

interface clfc_out_if;
    import clfc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] pwm_duty;
    logic              door_closed;
    logic              engine_running;

    modport source (output valid, output pwm_duty, output door_closed,
                    output engine_running, input ready);
    modport sink   (input valid, input pwm_duty, input door_closed,
                    input engine_running, output ready);
endinterface

`default_nettype wire

// ===== rtl/courtesy_lamp_fade_controller_top.sv =====
// A tick request accepted at a clock edge shows its result in the next cycle. Throughput:
// one tick per cycle while results are taken; all of a tick's work is one pass of counter
// and compare logic from the state registers into the state and result registers.
// The request side stalls only while the result register is full and not being taken.
// Reset (synchronous, active low) loads the default register values, a dark lamp,
// a closed door, a stopped engine, idle timers and an empty result register.
`default_nettype none

module courtesy_lamp_fade_controller_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [clfc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [clfc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    clfc_in_if.sink                          i_in,
    clfc_out_if.source                       o_out
);
    import clfc_pkg::*;

    // Configuration registers.
    logic [LEVEL_W-1:0] r_door_debounce;
    logic [LEVEL_W-1:0] r_engine_debounce;
    logic [LEVEL_W-1:0] r_fade_divider;
    logic [TIMER_W-1:0] r_off_delay;
    logic [TIMER_W-1:0] r_auto_off;
    logic [LEVEL_W-1:0] r_engine_thresh;
    logic [LEVEL_W-1:0] r_max_brightness;

    // Lamp and input state, updated once per accepted tick.
    logic [LEVEL_W-1:0] r_brightness,      n_brightness;
    logic               r_fade_up,         n_fade_up;
    logic               r_pending_fade_up, n_pending_fade_up;
    logic [TIMER_W-1:0] r_delay_count,     n_delay_count;
    logic [LEVEL_W-1:0] r_fade_step_count, n_fade_step_count;
    logic [TIMER_W-1:0] r_auto_off_count,  n_auto_off_count;
    logic               r_door_state,      n_door_state;
    logic [LEVEL_W-1:0] r_door_settle,     n_door_settle;
    logic               r_engine_state,    n_engine_state;
    logic [LEVEL_W-1:0] r_engine_settle,   n_engine_settle;

    // Result register.
    logic               r_out_valid;
    logic [DUTY_W-1:0]  r_duty,            n_duty;
    logic               r_door_closed;
    logic               r_engine_running;

    logic               in_accept;
    logic               engine_raw;

    // The result register frees up in the same cycle that its content is taken,
    // so a steady stream of ticks passes at one per cycle while results are taken.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;
    assign engine_raw = (i_in.supply_sample >= r_engine_thresh);

    // The whole tick in the order of its steps: off-delay countdown, fading,
    // door debounce, engine debounce, auto-off countdown, then the duty value.
    always_comb begin
        n_brightness      = r_brightness;
        n_fade_up         = r_fade_up;
        n_pending_fade_up = r_pending_fade_up;
        n_delay_count     = r_delay_count;
        n_fade_step_count = r_fade_step_count;
        n_auto_off_count  = r_auto_off_count;
        n_door_state      = r_door_state;
        n_door_settle     = r_door_settle;
        n_engine_state    = r_engine_state;
        n_engine_settle   = r_engine_settle;

        // Off-delay timer; a new direction is taken over once it has run out.
        if (n_delay_count != '0) begin
            n_delay_count = n_delay_count - TIMER_W'(1);
        end
        if (n_delay_count == '0 && n_fade_up != n_pending_fade_up) begin
            n_fade_up         = n_pending_fade_up;
            n_fade_step_count = '0;
        end

        // Fading: down one level every divider ticks, up one level every tick.
        if (!n_fade_up) begin
            if (n_brightness != '0) begin
                n_fade_step_count = n_fade_step_count + LEVEL_W'(1);
                if (n_fade_step_count >= r_fade_divider) begin
                    n_fade_step_count = '0;
                    n_brightness      = n_brightness - LEVEL_W'(1);
                end
            end
            if (n_brightness == '0 && n_delay_count == '0) begin
                n_fade_up         = n_pending_fade_up;
                n_fade_step_count = '0;
            end
        end else begin
            if (n_brightness < r_max_brightness) begin
                n_brightness = n_brightness + LEVEL_W'(1);
            end
            if (n_brightness == r_max_brightness && n_delay_count == '0) begin
                n_fade_up         = n_pending_fade_up;
                n_fade_step_count = '0;
            end
        end

        // Door debounce. A change arms the settle counter; the new level is taken
        // only if it still differs on the last count.
        if (n_door_settle == '0) begin
            if (i_in.door_level != n_door_state) begin
                n_door_settle = r_door_debounce;
            end
        end else begin
            if (n_door_settle == LEVEL_W'(1) && i_in.door_level != n_door_state) begin
                n_door_state = i_in.door_level;
                if (n_door_state) begin
                    // Door closed: dim at once with the engine running, else after the delay.
                    n_pending_fade_up = 1'b0;
                    n_auto_off_count  = '0;
                    n_delay_count     = n_engine_state ? '0 : r_off_delay;
                end else begin
                    n_delay_count     = '0;
                    n_pending_fade_up = 1'b1;
                    n_auto_off_count  = r_auto_off;
                end
            end
            n_door_settle = n_door_settle - LEVEL_W'(1);
        end

        // Engine debounce, seeing the door state of this same tick.
        if (n_engine_settle == '0) begin
            if (engine_raw != n_engine_state) begin
                n_engine_settle = r_engine_debounce;
            end
        end else begin
            if (n_engine_settle == LEVEL_W'(1) && engine_raw != n_engine_state) begin
                n_engine_state = engine_raw;
                if (n_engine_state) begin
                    if (n_door_state) begin
                        n_delay_count     = '0;
                        n_pending_fade_up = 1'b0;
                        n_auto_off_count  = '0;
                    end
                end else begin
                    n_delay_count     = '0;
                    n_pending_fade_up = 1'b1;
                    n_auto_off_count  = r_auto_off;
                end
            end
            n_engine_settle = n_engine_settle - LEVEL_W'(1);
        end

        // Auto-off: the lamp is switched off when the count reaches one.
        if (n_auto_off_count != '0) begin
            n_auto_off_count = n_auto_off_count - TIMER_W'(1);
            if (n_auto_off_count == TIMER_W'(1)) begin
                n_delay_count     = '0;
                n_pending_fade_up = 1'b0;
                n_auto_off_count  = '0;
            end
        end

        // Duty is four times the level, with the low bits filled at full brightness.
        n_duty = {n_brightness, 2'b00};
        if (n_brightness == r_max_brightness) begin
            n_duty = n_duty | DUTY_W'(3);
        end
    end

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_door_debounce   <= RST_DOOR_DEBOUNCE;
            r_engine_debounce <= RST_ENGINE_DEBOUNCE;
            r_fade_divider    <= RST_FADE_DIVIDER;
            r_off_delay       <= RST_OFF_DELAY;
            r_auto_off        <= RST_AUTO_OFF;
            r_engine_thresh   <= RST_ENGINE_THRESH;
            r_max_brightness  <= RST_MAX_BRIGHTNESS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DOOR_DEBOUNCE:   r_door_debounce   <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_ENGINE_DEBOUNCE: r_engine_debounce <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_FADE_DIVIDER:    r_fade_divider    <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_OFF_DELAY:       r_off_delay       <= i_cfg_wdata[TIMER_W-1:0];
                CFG_AUTO_OFF:        r_auto_off        <= i_cfg_wdata[TIMER_W-1:0];
                CFG_ENGINE_THRESH:   r_engine_thresh   <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_MAX_BRIGHTNESS:  r_max_brightness  <= i_cfg_wdata[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Tick state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness      <= '0;
            r_fade_up         <= 1'b0;
            r_pending_fade_up <= 1'b0;
            r_delay_count     <= '0;
            r_fade_step_count <= '0;
            r_auto_off_count  <= '0;
            r_door_state      <= 1'b1;
            r_door_settle     <= '0;
            r_engine_state    <= 1'b0;
            r_engine_settle   <= '0;
        end else if (in_accept) begin
            r_brightness      <= n_brightness;
            r_fade_up         <= n_fade_up;
            r_pending_fade_up <= n_pending_fade_up;
            r_delay_count     <= n_delay_count;
            r_fade_step_count <= n_fade_step_count;
            r_auto_off_count  <= n_auto_off_count;
            r_door_state      <= n_door_state;
            r_door_settle     <= n_door_settle;
            r_engine_state    <= n_engine_state;
            r_engine_settle   <= n_engine_settle;
        end
    end

    // Result register: valid is control, the payload loads with each tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_duty           <= n_duty;
            r_door_closed    <= n_door_state;
            r_engine_running <= n_engine_state;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.pwm_duty       = r_duty;
    assign o_out.door_closed    = r_door_closed;
    assign o_out.engine_running = r_engine_running;

    // Every accepted tick leaves a result waiting in the next cycle.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted tick left no result");

    // The state moves only on an accepted tick.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> $stable(r_brightness) && $stable(r_door_settle)
                       && $stable(r_engine_settle))
        else $error("tick state changed without a request");

    // The off delay runs only toward a fade-down.
    a_delay_means_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_delay_count != '0 |-> !r_pending_fade_up)
        else $error("off delay running with a fade-up pending");

    // The auto-off timer runs only while the lamp is meant to be on.
    a_auto_off_means_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_auto_off_count != '0 |-> r_pending_fade_up)
        else $error("auto-off running with the lamp switched off");

    // An empty result register never blocks the request side.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("request side stalled with an empty result register");

endmodule

`default_nettype wire
